### rtl/bsmt_pkg.sv
// ----------------------------------------------------------------------------
// bsmt_pkg
// shared types, field layouts and constants for the backing store map table
// ----------------------------------------------------------------------------
`default_nettype none

package bsmt_pkg;

    // table geometry and limits
    localparam int DEF_NUM_ENTRIES = 8;
    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
    localparam int MAX_PAGES       = 256;
    localparam int NUM_PROCS       = 64;
    localparam int OFFSET_LIMIT    = 1048575;

    // field widths
    localparam int MODE_W   = 3;
    localparam int PID_W    = 6;
    localparam int VADDR_W  = 32;
    localparam int SEL_W    = 3;
    localparam int BASE_W   = 20;
    localparam int COUNT_W  = 9;
    localparam int FOUND_W  = 3;
    localparam int OFFSET_W = 21;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;

    // page number of a byte address and the signed width of page minus base
    localparam int PAGE_W = VADDR_W - PAGE_SHIFT;
    localparam int DIFF_W = ((PAGE_W > BASE_W) ? PAGE_W : BASE_W) + 1;

    localparam logic signed [DIFF_W-1:0] LIM_POS = DIFF_W'(OFFSET_LIMIT);
    localparam logic signed [DIFF_W-1:0] LIM_NEG = -LIM_POS;

    typedef enum logic [MODE_W-1:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_MAP    = 3'd3,
        OP_UNMAP  = 3'd4
    } op_mode_t;

    // input beat, last field in the lowest bits
    typedef struct packed {
        logic [6:0]         fill;
        logic [COUNT_W-1:0] page_count;
        logic [BASE_W-1:0]  base_page;
        logic [SEL_W-1:0]   entry_sel;
        logic [VADDR_W-1:0] virt_addr;
        logic [PID_W-1:0]   proc_id;
        logic [MODE_W-1:0]  mode;
    } in_item_t;

    // result beat, last field in the lowest bits
    typedef struct packed {
        logic [6:0]                fill;
        logic signed [OFFSET_W-1:0] page_offset;
        logic [FOUND_W-1:0]        found_entry;
        logic                      status;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/bsmt_ctrl.sv
// ----------------------------------------------------------------------------
// bsmt_ctrl
// sequencer: accept, walk the table one entry a cycle, commit the result
// ----------------------------------------------------------------------------
`default_nettype none

module bsmt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire bsmt_pkg::dp_stat_t  stat,
    output bsmt_pkg::ctl_cmd_t       cmd
);
    import bsmt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.scan_step = (state_reg == ST_SCAN);
    assign cmd.commit    = (state_reg == ST_FINISH) && stat.out_free;

endmodule

`default_nettype wire

### rtl/bsmt_datapath.sv
// ----------------------------------------------------------------------------
// bsmt_datapath
// entry table, item registers, scan match, offset arithmetic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module bsmt_datapath #(
    parameter int NUM_ENTRIES = bsmt_pkg::DEF_NUM_ENTRIES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [bsmt_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bsmt_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire bsmt_pkg::ctl_cmd_t                cmd,
    output bsmt_pkg::dp_stat_t                     stat
);
    import bsmt_pkg::*;

    localparam int ENTRY_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [ENTRY_W-1:0] LAST_IDX = ENTRY_W'(NUM_ENTRIES - 1);

    // table; only the mapped flag is ever read without being mapped first,
    // so owner and base need no reset and a cleared entry just drops its flag
    logic [NUM_ENTRIES-1:0] mapped_reg;
    logic [PID_W-1:0]       owner_reg [NUM_ENTRIES];
    logic [BASE_W-1:0]      base_reg  [NUM_ENTRIES];

    in_item_t           item_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic               hit_reg;
    logic [ENTRY_W-1:0] hit_idx_reg;
    logic [BASE_W-1:0]  hit_base_reg;

    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic                       match;
    logic                       sel_ok;
    logic                       map_ok;
    logic [PAGE_W-1:0]          page;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   diff_sat;
    logic                       res_status;
    logic [FOUND_W-1:0]         res_entry;
    logic signed [OFFSET_W-1:0] res_offset;
    logic                       wr_map;
    logic                       wr_clr;
    logic [ENTRY_W-1:0]         wr_idx;
    out_item_t                  res_item;

    // match at the current walk position
    always_comb
    begin
        match = 1'b0;
        unique case (item_reg.mode)
            OP_ALLOC:
            begin
                match = !mapped_reg[idx_reg];
            end
            OP_LOOKUP, OP_UNMAP:
            begin
                match = mapped_reg[idx_reg] && (owner_reg[idx_reg] == item_reg.proc_id);
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
    end

    assign stat.scan_last = match || (idx_reg == LAST_IDX);
    assign stat.out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.scan_step && match)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item_t'(s_tdata);
            idx_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (match)
            begin
                hit_idx_reg  <= idx_reg;
                hit_base_reg <= base_reg[idx_reg];
            end
        end
    end

    // offset of the address page from the found base, clamped
    assign page = item_reg.virt_addr[VADDR_W-1:PAGE_SHIFT];
    assign diff = $signed(DIFF_W'(page)) - $signed(DIFF_W'(hit_base_reg));

    always_comb
    begin
        priority if (diff > LIM_POS)
        begin
            diff_sat = LIM_POS;
        end
        else if (diff < LIM_NEG)
        begin
            diff_sat = LIM_NEG;
        end
        else
        begin
            diff_sat = diff;
        end
    end

    assign sel_ok = (32'(item_reg.entry_sel) < NUM_ENTRIES);
    assign map_ok = sel_ok && (32'(item_reg.page_count) <= MAX_PAGES)
                    && (32'(item_reg.proc_id) < NUM_PROCS);

    // result and table update of the finished item
    always_comb
    begin
        res_status = 1'b1;
        res_entry  = '0;
        res_offset = '0;
        wr_map     = 1'b0;
        wr_clr     = 1'b0;
        wr_idx     = hit_idx_reg;
        unique case (item_reg.mode)
            OP_ALLOC:
            begin
                if (hit_reg)
                begin
                    res_status = 1'b0;
                    res_entry  = FOUND_W'(hit_idx_reg);
                end
            end
            OP_FREE:
            begin
                if (sel_ok)
                begin
                    res_status = 1'b0;
                    wr_clr     = 1'b1;
                    wr_idx     = ENTRY_W'(item_reg.entry_sel);
                end
            end
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_status = 1'b0;
                    res_entry  = FOUND_W'(hit_idx_reg);
                    res_offset = OFFSET_W'(diff_sat);
                end
            end
            OP_MAP:
            begin
                if (map_ok)
                begin
                    res_status = 1'b0;
                    wr_map     = 1'b1;
                    wr_idx     = ENTRY_W'(item_reg.entry_sel);
                end
            end
            OP_UNMAP:
            begin
                if (hit_reg)
                begin
                    res_status = 1'b0;
                    res_entry  = FOUND_W'(hit_idx_reg);
                    wr_clr     = 1'b1;
                end
            end
            default:
            begin
                res_status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapped_reg <= '0;
        end
        else if (cmd.commit && wr_map)
        begin
            mapped_reg[wr_idx] <= 1'b1;
        end
        else if (cmd.commit && wr_clr)
        begin
            mapped_reg[wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_map)
        begin
            owner_reg[wr_idx] <= item_reg.proc_id;
            base_reg[wr_idx]  <= item_reg.base_page;
        end
    end

    // result register
    always_comb
    begin
        res_item             = '0;
        res_item.status      = res_status;
        res_item.found_entry = res_entry;
        res_item.page_offset = res_offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            m_data_reg <= res_item;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a result never overwrites one still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_valid_reg || m_tready))
        else $error("commit while result pending");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    // the walk stops at the first hit
    a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !hit_reg)
        else $error("walk continued past a hit");

endmodule

`default_nettype wire

### rtl/backing_store_map_table_top.sv
// ----------------------------------------------------------------------------
// backing_store_map_table_top
// table of backing store entries with allocate, free, lookup, map and unmap
// ----------------------------------------------------------------------------
//  channel  dir  beat payload
//  s_*      in   mode, proc_id, virt_addr, entry_sel, base_page, page_count
//  m_*      out  status, found_entry, page_offset
//
//  an item goes from accept to the next accept through the accept itself,
//  a walk over the entries at one per cycle that stops at the first hit,
//  and the commit; free and map walk every entry
//  s_tready is high only while the sequencer is idle; a finished result may
//  wait in the output register while the next item is taken
//  a stalled result holds the next item at its commit cycle
//  reset clears every entry to unmapped; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module backing_store_map_table_top #(
    parameter int NUM_ENTRIES = bsmt_pkg::DEF_NUM_ENTRIES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // mode[2:0], proc_id[8:3], virt_addr[40:9], entry_sel[43:41],
    // base_page[63:44], page_count[72:64], zero[79:73]
    input  wire logic [bsmt_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // status[0], found_entry[3:1], page_offset[24:4] (signed), zero[31:25]
    output logic [bsmt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);
    import bsmt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer: idle, walk, commit
    bsmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, match logic and result register
    bsmt_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire
